[hdl/pbe_pkg.sv]
// Package for the padded base32 encoder: widths, the job record passed
// from front to back, and the 32-letter alphabet table.
// No dependencies.
`timescale 1ns / 1ps

package pbe_pkg;

    localparam int SYM_BITS    = 5;
    localparam int ACC_BITS    = 16;
    localparam int CNT_BITS    = 4;
    localparam int PAD_BITS    = 3;
    localparam int PEND_BITS   = 3;
    localparam int BYTE_BITS   = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PAD_BITS-1:0] MAX_PAD = 3'd4;

    typedef struct packed {
        logic [ACC_BITS-1:0] acc;
        logic [CNT_BITS-1:0] bits;
        logic [PAD_BITS-1:0] pad;
        logic                last;
    } job_t;

    localparam logic [7:0] ALPHABET [0:31] = '{
        "1", "3", "4", "5", "6", "7", "8", "9",
        "a", "b", "c", "d", "e", "f", "g", "h",
        "i", "j", "k", "m", "n", "o", "p", "q",
        "r", "s", "t", "u", "w", "x", "y", "z"
    };

endpackage

[hdl/pbe_in_if.sv]
// Input channel of the padded base32 encoder: one message byte per request.
// Depends on pbe_pkg.
`timescale 1ns / 1ps

interface pbe_in_if;
    logic                          valid;
    logic                          ready;
    logic [pbe_pkg::BYTE_BITS-1:0] data_byte;
    logic                          first_byte;
    logic                          last_byte;
    logic [pbe_pkg::PAD_BITS-1:0]  pad_bits;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, output pad_bits, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, input pad_bits, output ready);
endinterface

[hdl/pbe_out_if.sv]
// Output channel of the padded base32 encoder: one character per request.
// Depends on pbe_pkg.
`timescale 1ns / 1ps

interface pbe_out_if;
    logic                         valid;
    logic                         ready;
    logic [7:0]                   char_code;
    logic [pbe_pkg::SYM_BITS-1:0] symbol;
    logic                         last_char;

    modport source (output valid, output char_code, output symbol,
                    output last_char, input ready);
    modport sink   (input valid, input char_code, input symbol,
                    input last_char, output ready);
endinterface

[hdl/pbe_front.sv]
// Front end: accepts message bytes, keeps the bit accumulator state and
// turns each byte into a job for the back end. Depends on pbe_pkg, pbe_in_if.
`timescale 1ns / 1ps

module pbe_front (
    input  logic          clk,
    input  logic          rst_n,
    pbe_in_if.sink        in_ch,
    output pbe_pkg::job_t job,
    output logic          push_valid,
    input  logic          push_ready
);

    logic [pbe_pkg::ACC_BITS-1:0]  acc_reg, acc_next;
    logic [pbe_pkg::PEND_BITS-1:0] pend_reg, pend_next;
    logic [pbe_pkg::PAD_BITS-1:0]  pad_reg, pad_next;

    logic [pbe_pkg::BYTE_BITS-1:0] base_acc;
    logic [pbe_pkg::PEND_BITS-1:0] base_pend;
    logic [pbe_pkg::PAD_BITS-1:0]  pad_sat;
    logic [pbe_pkg::PAD_BITS-1:0]  pad_eff;
    logic                          accept;

    always_comb
    begin
        pad_sat   = (in_ch.pad_bits > pbe_pkg::MAX_PAD) ? pbe_pkg::MAX_PAD : in_ch.pad_bits;
        base_acc  = in_ch.first_byte ? '0 : acc_reg[pbe_pkg::BYTE_BITS-1:0];
        base_pend = in_ch.first_byte ? '0 : pend_reg;
        pad_eff   = in_ch.first_byte ? pad_sat : pad_reg;

        job.acc  = {base_acc, in_ch.data_byte};
        job.bits = {1'b0, base_pend} + pbe_pkg::CNT_BITS'(pbe_pkg::BYTE_BITS);
        job.pad  = pad_eff;
        job.last = in_ch.last_byte;

        push_valid  = in_ch.valid;
        in_ch.ready = push_ready;
        accept      = in_ch.valid && push_ready;

        acc_next  = acc_reg;
        pend_next = pend_reg;
        pad_next  = pad_reg;
        if (accept)
        begin
            if (in_ch.last_byte)
            begin
                acc_next  = '0;
                pend_next = '0;
                pad_next  = '0;
            end
            else
            begin
                acc_next = job.acc;
                pad_next = pad_eff;
                if (job.bits >= pbe_pkg::CNT_BITS'(2 * pbe_pkg::SYM_BITS))
                    pend_next = pbe_pkg::PEND_BITS'(job.bits
                                - pbe_pkg::CNT_BITS'(2 * pbe_pkg::SYM_BITS));
                else
                    pend_next = pbe_pkg::PEND_BITS'(job.bits
                                - pbe_pkg::CNT_BITS'(pbe_pkg::SYM_BITS));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= '0;
            pad_reg  <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            pad_reg  <= pad_next;
        end
    end

endmodule

[hdl/pbe_queue.sv]
// Job queue between front and back end of the padded base32 encoder.
// Depends on pbe_pkg.
`timescale 1ns / 1ps

module pbe_queue #(
    parameter int DEPTH = pbe_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  pbe_pkg::job_t push_job,
    input  logic          push_valid,
    output logic          push_ready,
    output pbe_pkg::job_t pop_job,
    output logic          pop_valid,
    input  logic          pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pbe_pkg::job_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    always_comb
    begin
        push_ready = (count_reg < CNT_W'(DEPTH));
        pop_valid  = (count_reg != '0);
        pop_job    = mem_reg[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/pbe_back.sv]
// Back end: takes queued jobs and emits one base32 character per cycle
// into the output register unless stalled. Depends on pbe_pkg, pbe_out_if.
`timescale 1ns / 1ps

module pbe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  pbe_pkg::job_t pop_job,
    input  logic          pop_valid,
    output logic          pop_ready,
    pbe_out_if.source     out_ch
);

    localparam logic [pbe_pkg::CNT_BITS-1:0] SYM_CNT = pbe_pkg::CNT_BITS'(pbe_pkg::SYM_BITS);
    localparam logic [pbe_pkg::CNT_BITS:0]   SYM_WIN = (pbe_pkg::CNT_BITS + 1)'(pbe_pkg::SYM_BITS);

    logic                          active_reg, active_next;
    logic [pbe_pkg::CNT_BITS-1:0]  rem_reg, rem_next;
    logic [pbe_pkg::ACC_BITS-1:0]  acc_reg, acc_next;
    logic [pbe_pkg::PAD_BITS-1:0]  pad_reg, pad_next;
    logic                          last_reg, last_next;

    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    char_reg, char_next;
    logic [pbe_pkg::SYM_BITS-1:0]  sym_reg, sym_next;
    logic                          lastc_reg, lastc_next;

    logic                          advance;
    logic                          is_normal;
    logic                          done;
    logic [pbe_pkg::CNT_BITS:0]    window;
    logic [pbe_pkg::CNT_BITS-1:0]  step_rem;
    logic [pbe_pkg::ACC_BITS-1:0]  shifted;
    logic [pbe_pkg::SYM_BITS-1:0]  sym;

    always_comb
    begin
        advance   = active_reg && (!out_valid_reg || out_ch.ready);
        is_normal = (rem_reg >= SYM_CNT);
        window    = {1'b0, rem_reg} + {2'b00, pad_reg};
        step_rem  = rem_reg - SYM_CNT;

        if (window <= SYM_WIN)
            shifted = acc_reg << (SYM_WIN - window);
        else
            shifted = acc_reg >> (window - SYM_WIN);
        sym = shifted[pbe_pkg::SYM_BITS-1:0];

        if (is_normal)
            done = !((step_rem >= SYM_CNT) || (last_reg && (step_rem != '0)));
        else
            done = 1'b1;

        pop_ready = !active_reg || (advance && done);

        active_next = active_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        pad_next    = pad_reg;
        last_next   = last_reg;
        if (pop_valid && pop_ready)
        begin
            active_next = 1'b1;
            rem_next    = pop_job.bits;
            acc_next    = pop_job.acc;
            pad_next    = pop_job.pad;
            last_next   = pop_job.last;
        end
        else if (advance && done)
            active_next = 1'b0;
        else if (advance)
            rem_next = step_rem;

        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        sym_next       = sym_reg;
        lastc_next     = lastc_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            char_next      = pbe_pkg::ALPHABET[sym];
            sym_next       = sym;
            lastc_next     = last_reg && done;
        end
        else if (out_ch.ready)
            out_valid_next = 1'b0;

        out_ch.valid     = out_valid_reg;
        out_ch.char_code = char_reg;
        out_ch.symbol    = sym_reg;
        out_ch.last_char = lastc_reg;
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
        pad_reg   <= pad_next;
        last_reg  <= last_next;
        char_reg  <= char_next;
        sym_reg   <= sym_next;
        lastc_reg <= lastc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/padded_base32_encoder_top.sv]
// Padded base32 encoder, top level: front end, job queue, back end.
// Depends on pbe_pkg, pbe_in_if, pbe_out_if, pbe_front, pbe_queue, pbe_back.
//
// Usage: in_ch carries one message byte per request, MSB first. Mark the
// first byte with first_byte and give the leading pad count (0..4, larger
// values count as 4) with it; mark the final byte with last_byte. out_ch
// carries one character per request: its ASCII code, its 5-bit symbol, and
// last_char on the final character of a message.
// Path: an accepted byte's job passes through the job queue and the back-end
// job registers before its first character reaches the output register. The
// back end emits one character per cycle unless out_ch stalls; a byte yields
// 1 to 3 characters (1.6 on average for whole messages). The front end takes
// a byte every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Reset clears the accumulator, pending count, pad, queue and output valid
// flag. When the receiver stalls, the output register holds its character,
// the back end stops, and the queue fills before in_ch.ready drops.
`timescale 1ns / 1ps

module padded_base32_encoder_top #(
    parameter int QUEUE_DEPTH = pbe_pkg::QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    pbe_in_if.sink    in_ch,
    pbe_out_if.source out_ch
);

    pbe_pkg::job_t front_job;
    pbe_pkg::job_t queue_job;
    logic          push_valid, push_ready;
    logic          pop_valid, pop_ready;

    pbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .job        (front_job),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    pbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (queue_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    pbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_job   (queue_job),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .out_ch    (out_ch)
    );

`ifndef NO_ASSERTIONS
    a_push_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready) |-> (front_job.bits >= 4'd8 && front_job.bits <= 4'd12))
        else $error("job bit count out of range at push");

    a_push_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready) |-> (front_job.pad <= pbe_pkg::MAX_PAD))
        else $error("job pad exceeds maximum at push");

    a_pop_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |-> (queue_job.bits >= 4'd8 && queue_job.bits <= 4'd12))
        else $error("queued job bit count out of range at pop");
`endif

endmodule
